// File: rtl/cbez_pkg.sv
package cbez_pkg;

  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_SOLVX = 2'd1,
    OP_SOLVY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EVWAIT,
    ST_SCHK,
    ST_SSTEP,
    ST_SWAIT,
    ST_SUPD,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_DONE
  } state_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;      // capture the item and the control points
    logic ev_start;  // start a pair of curve evaluations at the current t
    logic ev_tq;     // t comes from the query (evaluate) rather than the guess
    logic end_chk;   // decide the end clamp
    logic upd;       // fold the samples into the bracket
    logic div_start; // start the interpolation divide
    logic fin_eval;  // result from the evaluation pair
    logic fin_div;   // result from the interpolation
    logic fin_zero;  // unused opcode
  } cmd_t;

  typedef struct packed {
    logic ev_done;
    logic clamped;   // end clamp took the result
    logic last_step; // bisection steps used up
    logic div_done;
    logic eq_bracket;
  } sts_t;

  localparam int unsigned REG_COUNT = 8;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

endpackage

// File: rtl/cubic_bezier_eval_and_solve.sv
// Channel | Direction | Signals
// input   | in        | in_valid, in_ready, in_opcode, in_query, in_halvings
// result  | out       | out_valid, out_ready, out_answer_x, out_answer_y
// config  | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// An evaluation starts once the item is accepted, then the two serial de Casteljau
// units run six lerps each before the result beat shows.
// A solve runs the end check, then its halving steps, each a pair of curve
// evaluations, then the divide set-up and the restoring divider; an end clamp skips
// the steps and the divide, and an equal bracket skips the divide.
// One item is worked at a time; the result beat holds until it is taken.
// Reset is synchronous and active low and sets the control points to their defaults.
module cubic_bezier_eval_and_solve #(
  parameter int unsigned MAX_HALVINGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic signed [31:0] in_query,
  input  logic [4:0]  in_halvings,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_answer_x,
  output logic signed [31:0] out_answer_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cbez_pkg::*;

  logic signed [31:0] pts_r [8];
  cmd_t cmd;
  sts_t sts;
  logic busy;

  assign pready = 1'b1;
  assign prdata = pts_r[paddr[4:2]];

  // Control point registers; a write lands on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r[0] <= '0; pts_r[1] <= '0; pts_r[2] <= '0; pts_r[3] <= '0;
      pts_r[4] <= ONE_Q16; pts_r[5] <= ONE_Q16;
      pts_r[6] <= ONE_Q16; pts_r[7] <= ONE_Q16;
    end else if (psel && penable && pwrite) begin
      pts_r[paddr[4:2]] <= pwdata;
    end
  end

  assign in_ready = ~busy;

  cbez_ctrl u_ctrl (.clk, .rst_n, .in_go(in_valid & ~busy), .in_op(in_opcode),
    .out_taken(out_ready), .sts, .cmd, .busy, .res_valid(out_valid));

  cbez_dp #(.MAX_HALVINGS(MAX_HALVINGS)) u_dp (.clk, .rst_n, .cmd, .sts,
    .in_op(in_opcode), .in_q(in_query), .in_n(in_halvings), .pts(pts_r),
    .ans_x(out_answer_x), .ans_y(out_answer_y));

  // The block never takes an item while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");
  // A result not taken stays on the port.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_answer_x))
    else $error("result changed before it was taken");
  // An accepted item makes the block busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block stayed ready after accepting");

endmodule

// File: rtl/cbez_ctrl.sv
module cbez_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_go,
  input  logic [1:0]     in_op,
  input  logic           out_taken,
  input  cbez_pkg::sts_t sts,
  output cbez_pkg::cmd_t cmd,
  output logic           busy,
  output logic           res_valid
);
  import cbez_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    busy      = 1'b1;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_go) begin
          cmd.load  = 1'b1;
          op_nxt    = op_t'(in_op);
          case (op_t'(in_op))
            OP_EVAL:  state_nxt = ST_EVAL;
            OP_SOLVX, OP_SOLVY: state_nxt = ST_SCHK;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_EVAL: begin
        cmd.ev_start = 1'b1;
        cmd.ev_tq    = 1'b1;
        state_nxt    = ST_EVWAIT;
      end
      ST_EVWAIT: if (sts.ev_done) begin
        cmd.fin_eval = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_SCHK: begin
        cmd.end_chk = 1'b1;
        state_nxt   = ST_SSTEP;
      end
      ST_SSTEP: begin
        if (sts.clamped) state_nxt = ST_DONE;
        else if (sts.last_step) state_nxt = ST_DIVGO;
        else begin
          cmd.ev_start = 1'b1;
          state_nxt    = ST_SWAIT;
        end
      end
      ST_SWAIT: if (sts.ev_done) state_nxt = ST_SUPD;
      ST_SUPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_SSTEP;
      end
      ST_DIVGO: begin
        if (sts.eq_bracket) begin
          cmd.fin_div = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVWAIT;
        end
      end
      ST_DIVWAIT: if (sts.div_done) begin
        cmd.fin_div = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (op_r == OP_NONE) cmd.fin_zero = 1'b1;
        if (out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/cbez_lerp.sv
// Serial de Casteljau: six lerps in turn, sharing two multipliers.
module cbez_lerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] c0,
  input  logic signed [31:0] c1,
  input  logic signed [31:0] c2,
  input  logic signed [31:0] c3,
  input  logic [16:0]        t,
  output logic               done,
  output logic signed [31:0] res
);
  logic [2:0] idx_r, idx_nxt;
  logic       run_r, run_nxt;
  logic signed [31:0] m01_r, m12_r, m23_r, a_r, b_r, res_r;
  logic signed [31:0] la, lb;
  logic signed [49:0] pa_r, pb_r;
  logic               ph_r, ph_nxt;
  logic signed [51:0] sum;
  logic signed [31:0] lq;

  always_comb begin
    case (idx_r)
      3'd0: begin la = c0; lb = c1; end
      3'd1: begin la = c1; lb = c2; end
      3'd2: begin la = c2; lb = c3; end
      3'd3: begin la = m01_r; lb = m12_r; end
      3'd4: begin la = m12_r; lb = m23_r; end
      default: begin la = a_r; lb = b_r; end
    endcase
    sum = 52'(pa_r) + 52'(pb_r) + 52'sd32768;
    lq  = 32'(sum >>> 16);
  end

  // Phase 0 multiplies, phase 1 sums and stores.
  always_comb begin
    run_nxt = run_r;
    idx_nxt = idx_r;
    ph_nxt  = ph_r;
    done    = 1'b0;
    if (start) begin
      run_nxt = 1'b1; idx_nxt = '0; ph_nxt = 1'b0;
    end else if (run_r) begin
      ph_nxt = ~ph_r;
      if (ph_r) begin
        if (idx_r == 3'd5) begin
          run_nxt = 1'b0;
          done    = 1'b1;
        end
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; idx_r <= '0; ph_r <= 1'b0;
    end else begin
      run_r <= run_nxt; idx_r <= idx_nxt; ph_r <= ph_nxt;
    end
    if (run_r && !ph_r) begin
      pa_r <= la * $signed({1'b0, 17'(18'd65536 - {1'b0, t})});
      pb_r <= lb * $signed({1'b0, t});
    end
    if (run_r && ph_r) begin
      case (idx_r)
        3'd0: m01_r <= lq;
        3'd1: m12_r <= lq;
        3'd2: m23_r <= lq;
        3'd3: a_r <= lq;
        3'd4: b_r <= lq;
        default: res_r <= lq;
      endcase
    end
  end

  assign res = (run_r && ph_r && idx_r == 3'd5) ? lq : res_r;

endmodule

// File: rtl/cbez_div.sv
// Restoring divider: q = a*b/c, one quotient bit per cycle, saturated to 2^34.
module cbez_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] a,
  input  logic [33:0] b,
  input  logic [33:0] c,
  output logic        done,
  output logic [34:0] q
);
  localparam logic [34:0] QSAT = 35'h4_0000_0000;
  logic [67:0] num_r;
  logic [34:0] rem_r;
  logic [41:0] q_r;
  logic        big_r;
  logic [33:0] c_r;
  logic [6:0]  cnt_r;
  logic [1:0]  ph_r;
  logic [16:0] pl_r;
  logic [35:0] trial;
  logic        fin;

  assign trial = {rem_r, num_r[67]} - {2'b0, c_r};
  assign fin   = (ph_r == 2'd2) && (cnt_r == 7'd68);
  assign done  = fin;
  assign q = (big_r || q_r > 42'(QSAT)) ? QSAT :
             35'(q_r);

  // The product is formed as two 34x17 partial products, one after the other.
  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= 2'd0;
    else if (start) ph_r <= 2'd1;
    else if (ph_r == 2'd1) ph_r <= 2'd3;
    else if (ph_r == 2'd3) ph_r <= 2'd2;
    else if (fin) ph_r <= 2'd0;
    if (start) begin
      c_r <= c; rem_r <= '0; q_r <= '0; big_r <= 1'b0; cnt_r <= '0;
      num_r <= 68'(a * b[16:0]);
      pl_r  <= b[33:17];
    end else if (ph_r == 2'd1) begin
      num_r <= num_r + (68'(a * pl_r) << 17);
    end else if (ph_r == 2'd2 && !fin) begin
      if (q_r >= 42'h100_0000_0000) big_r <= 1'b1;
      if (!trial[35]) begin
        rem_r <= trial[34:0];
        q_r   <= {q_r[40:0], 1'b1};
      end else begin
        rem_r <= {rem_r[33:0], num_r[67]};
        q_r   <= {q_r[40:0], 1'b0};
      end
      num_r <= {num_r[66:0], 1'b0};
      cnt_r <= cnt_r + 7'd1;
    end
  end

endmodule

// File: rtl/cbez_dp.sv
module cbez_dp #(
  parameter int unsigned MAX_HALVINGS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbez_pkg::cmd_t     cmd,
  output cbez_pkg::sts_t     sts,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_q,
  input  logic [4:0]         in_n,
  input  logic signed [31:0] pts [8],
  output logic signed [31:0] ans_x,
  output logic signed [31:0] ans_y
);
  import cbez_pkg::*;

  logic signed [31:0] so_r [4];
  logic signed [31:0] ss_r [4];
  logic signed [31:0] q_r, lo_o_r, lo_s_r, hi_o_r, hi_s_r, vo, vs;
  logic [4:0]  n_r, i_r;
  logic [17:0] guess_r;
  logic        up_r, clamp_r;
  logic [16:0] t, tq, t_r;
  logic        ev_do, ev_ds;
  logic signed [31:0] rx_r, ry_r;
  logic signed [32:0] da, db, dc;
  logic        neg_r;
  logic [34:0] mq;
  logic        ddone;
  logic signed [35:0] rsum;

  // The curve parameter is held for the whole evaluation.
  assign tq = q_r[31] ? 17'd0 : (q_r > ONE_Q16 ? 17'd65536 : q_r[16:0]);
  assign t  = t_r;

  cbez_lerp u_lo (.clk, .rst_n, .start(cmd.ev_start), .c0(so_r[0]), .c1(so_r[1]),
    .c2(so_r[2]), .c3(so_r[3]), .t, .done(ev_do), .res(vo));
  cbez_lerp u_ls (.clk, .rst_n, .start(cmd.ev_start), .c0(ss_r[0]), .c1(ss_r[1]),
    .c2(ss_r[2]), .c3(ss_r[3]), .t, .done(ev_ds), .res(vs));

  assign da = 33'(hi_o_r) - 33'(lo_o_r);
  assign db = 33'(q_r) - 33'(lo_s_r);
  assign dc = 33'(hi_s_r) - 33'(lo_s_r);

  cbez_div u_div (.clk, .rst_n, .start(cmd.div_start),
    .a(da[32] ? 34'(-34'(da)) : 34'(da)), .b(db[32] ? 34'(-34'(db)) : 34'(db)),
    .c(dc[32] ? 34'(-34'(dc)) : 34'(dc)), .done(ddone), .q(mq));

  assign rsum = neg_r ? 36'(lo_o_r) - 36'(mq) : 36'(lo_o_r) + 36'(mq);

  assign sts.ev_done    = ev_do & ev_ds;
  assign sts.clamped    = clamp_r;
  assign sts.last_step  = (i_r == n_r);
  assign sts.div_done   = ddone;
  assign sts.eq_bracket = (lo_s_r == hi_s_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) begin
        so_r[k] <= (in_op == OP_SOLVY) ? pts[2*k+1] : pts[2*k];
        ss_r[k] <= (in_op == OP_SOLVY) ? pts[2*k] : pts[2*k+1];
      end
      q_r     <= in_q;
      n_r     <= (32'(in_n) > MAX_HALVINGS) ? 5'(MAX_HALVINGS) : in_n;
      i_r     <= '0;
      guess_r <= 18'd32768;
      clamp_r <= 1'b0;
      ry_r    <= '0;
      rx_r    <= '0;
    end
    if (cmd.ev_start) t_r <= cmd.ev_tq ? tq : guess_r[16:0];
    if (cmd.end_chk) begin
      up_r   <= ss_r[0] < ss_r[3];
      lo_o_r <= so_r[0]; lo_s_r <= ss_r[0];
      hi_o_r <= so_r[3]; hi_s_r <= ss_r[3];
      if (ss_r[0] < ss_r[3]) begin
        if (q_r < ss_r[0]) begin clamp_r <= 1'b1; rx_r <= so_r[0]; end
        else if (q_r > ss_r[3]) begin clamp_r <= 1'b1; rx_r <= so_r[3]; end
      end else begin
        if (q_r < ss_r[3]) begin clamp_r <= 1'b1; rx_r <= so_r[3]; end
        else if (q_r > ss_r[0]) begin clamp_r <= 1'b1; rx_r <= so_r[0]; end
      end
    end
    if (cmd.upd) begin
      if ((vs < q_r) == up_r) begin
        guess_r <= guess_r + (18'd32768 >> i_r);
        lo_o_r <= vo; lo_s_r <= vs;
      end else begin
        guess_r <= guess_r - (18'd32768 >> i_r);
        hi_o_r <= vo; hi_s_r <= vs;
      end
      i_r <= i_r + 5'd1;
    end
    if (cmd.div_start) neg_r <= da[32] ^ db[32] ^ dc[32];
    if (cmd.fin_eval) begin rx_r <= vo; ry_r <= vs; end
    if (cmd.fin_div) begin
      if (lo_s_r == hi_s_r) rx_r <= lo_o_r;
      else if (rsum > 36'sh7FFF_FFFF) rx_r <= 32'sh7FFF_FFFF;
      else if (rsum < -36'sh8000_0000) rx_r <= 32'sh8000_0000;
      else rx_r <= rsum[31:0];
    end
    if (cmd.fin_zero) begin rx_r <= '0; ry_r <= '0; end
  end

  assign ans_x = rx_r;
  assign ans_y = ry_r;

endmodule
